// ===== sv/rfbre_pkg.sv =====
// Shared types, constants and command codes of the rotated framebuffer raster engine.
`default_nettype none

package rfbre_pkg;

  localparam int unsigned FB_BYTES   = 8192;
  localparam int unsigned FB_AW      = $clog2(FB_BYTES);
  localparam int unsigned POS_W      = 21;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned MAP_W      = 13;
  localparam int unsigned BADDR_W    = 13;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DAT_W  = 11;

  localparam logic [7:0] PIX_MSB  = 8'h80;
  localparam logic [1:0] ROT_MASK = 2'h3;

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_RECT  = 3'd3;
  localparam logic [2:0] OP_BOX   = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;
  localparam logic [2:0] OP_WRITE = 3'd6;

  localparam logic [1:0] COL_BLACK = 2'd0;
  localparam logic [1:0] COL_WHITE = 2'd1;
  localparam logic [1:0] COL_RED   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 3'd6;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [COORD_W-1:0] x_first;
    logic signed [COORD_W-1:0] y_first;
    logic signed [COORD_W-1:0] x_second;
    logic signed [COORD_W-1:0] y_second;
    logic [1:0]                color;
    logic [BADDR_W-1:0]        byte_addr;
    logic [7:0]                black_byte_in;
    logic [7:0]                red_byte_in;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/rotated_framebuffer_raster_engine.sv =====
// Top level of the rotated two-plane framebuffer raster engine.
// Commands arrive as beats on the slave stream: tuser carries the opcode and tdata the
// coordinates, colour, byte address and write bytes. Each command returns exactly one beat
// on the master stream with a status flag and, for a byte read, the two plane bytes.
// Settings are written through the configuration port; the user must write them only while
// the engine is idle, as the block itself does not enforce this. Every pixel is rotated,
// optionally padded, mapped to a byte address by the single address multiplier and, if it
// lies inside the buffer, updated by a read-modify-write of both plane memories. A pixel
// inside the buffer passes the map, address, read and write states and a dropped pixel
// only map and address; each line, box row and rectangle edge adds a setup state. Byte
// reads and writes take the byte state instead. The single-port memories need a read
// before each pixel write. The engine takes one command at a time; tready is high only
// while it is idle, so a new command is not taken before the last one's result has been
// loaded into the output register.
// A finished result waits in an output register, so the next command is accepted while
// the receiver stalls; a second result then waits until the first beat has gone.
// Reset restores the default settings and empties the output register; the plane memories
// are not cleared and hold unknown data until written.
`default_nettype none

module rotated_framebuffer_raster_engine (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // x_first, y_first, x_second, y_second, color, byte_addr, black_byte_in, red_byte_in
  input  wire logic [rfbre_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op
  input  wire logic [rfbre_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // status, black_byte_out, red_byte_out
  output      logic [rfbre_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  wire logic                                cfg_we_i,
  input  wire logic [rfbre_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rfbre_pkg::CFG_DAT_W-1:0]     cfg_wdata_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEG  = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_BYTE = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam int unsigned CW = rfbre_pkg::COORD_W;
  localparam int unsigned MW = rfbre_pkg::MAP_W;
  localparam int unsigned PW = rfbre_pkg::POS_W;
  localparam int unsigned AW = rfbre_pkg::FB_AW;

  // Configuration registers.
  logic [1:0]  rotation_q;
  logic        mirror_q;
  logic        red_en_q;
  logic [10:0] width_q;
  logic [10:0] height_q;
  logic [7:0]  pad_q;
  logic [7:0]  row_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q  <= 2'd0;
      mirror_q    <= 1'b0;
      red_en_q    <= 1'b0;
      width_q     <= 11'd128;
      height_q    <= 11'd296;
      pad_q       <= 8'd0;
      row_bytes_q <= 8'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rfbre_pkg::REG_ROTATION:  rotation_q  <= cfg_wdata_i[1:0] & rfbre_pkg::ROT_MASK;
        rfbre_pkg::REG_MIRROR:    mirror_q    <= cfg_wdata_i[0];
        rfbre_pkg::REG_RED_EN:    red_en_q    <= cfg_wdata_i[0];
        rfbre_pkg::REG_WIDTH:     width_q     <= cfg_wdata_i;
        rfbre_pkg::REG_HEIGHT:    height_q    <= cfg_wdata_i;
        rfbre_pkg::REG_PAD:       pad_q       <= cfg_wdata_i[7:0];
        rfbre_pkg::REG_ROW_BYTES: row_bytes_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Command unpacking.
  rfbre_pkg::cmd_t in_cmd;
  assign in_cmd.op            = s_axis_tuser;
  assign in_cmd.x_first       = s_axis_tdata[10:0];
  assign in_cmd.y_first       = s_axis_tdata[21:11];
  assign in_cmd.x_second      = s_axis_tdata[32:22];
  assign in_cmd.y_second      = s_axis_tdata[43:33];
  assign in_cmd.color         = s_axis_tdata[45:44];
  assign in_cmd.byte_addr     = s_axis_tdata[58:46];
  assign in_cmd.black_byte_in = s_axis_tdata[66:59];
  assign in_cmd.red_byte_in   = s_axis_tdata[74:67];

  logic [2:0]            state_q, state_d;
  rfbre_pkg::cmd_t       cmd_q, cmd_d;
  logic signed [CW-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d, end_q, end_d, row_q, row_d;
  logic                  horiz_q, horiz_d;
  logic [1:0]            seg_q, seg_d;
  logic                  dropped_q, dropped_d;
  logic signed [MW-1:0]  nx_q, nx_d, ny_q, ny_d;
  logic [AW-1:0]         pix_addr_q, pix_addr_d;
  logic [2:0]            bit_q, bit_d;
  logic                  m_valid_q, m_valid_d;
  logic [rfbre_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic [7:0]            rd_black_q, rd_red_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [7:0]            wr_black, wr_red;

  logic                  accept;
  logic signed [CW-1:0]  x1, y1, x2, y2, x_lo, x_hi, y_lo, y_hi, run_pos;
  logic signed [MW-1:0]  cx_ext, cy_ext, w_ext, h_ext, pad_ext;
  logic [PW-1:0]         pos, rw_addr;
  logic                  addr_drop, byte_ok;
  logic [7:0]            mask;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign x1   = cmd_q.x_first;
  assign y1   = cmd_q.y_first;
  assign x2   = cmd_q.x_second;
  assign y2   = cmd_q.y_second;
  assign x_lo = (x1 > x2) ? x2 : x1;
  assign x_hi = (x1 > x2) ? x1 : x2;
  assign y_lo = (y1 > y2) ? y2 : y1;
  assign y_hi = (y1 > y2) ? y1 : y2;

  assign cx_ext  = MW'(cur_x_q);
  assign cy_ext  = MW'(cur_y_q);
  assign w_ext   = $signed({2'b00, width_q});
  assign h_ext   = $signed({2'b00, height_q});
  assign pad_ext = $signed({5'b00000, pad_q});

  // Shared address unit: row times pitch plus byte column.
  assign pos       = PW'(ny_q[MW-2:0]) * PW'(row_bytes_q) + PW'(nx_q[MW-2:3]);
  assign addr_drop = nx_q[MW-1] || ny_q[MW-1] || (pos >= PW'(rfbre_pkg::FB_BYTES));
  assign rw_addr   = PW'(cmd_q.byte_addr);
  assign byte_ok   = rw_addr < PW'(rfbre_pkg::FB_BYTES);

  assign run_pos = horiz_q ? cur_x_q : cur_y_q;
  assign mask    = rfbre_pkg::PIX_MSB >> bit_q;

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = pix_addr_q;
    wr_black = (cmd_q.color != rfbre_pkg::COL_WHITE) ? (rd_black_q & ~mask) : rd_black_q;
    wr_red   = (red_en_q && cmd_q.color == rfbre_pkg::COL_RED) ? (rd_red_q | mask) : rd_red_q;
    if (state_q == S_RD) begin
      mem_re = 1'b1;
    end else if (state_q == S_WR) begin
      mem_we = 1'b1;
    end else if (state_q == S_BYTE) begin
      mem_addr = rw_addr[AW-1:0];
      wr_black = cmd_q.black_byte_in;
      wr_red   = cmd_q.red_byte_in;
      mem_re   = byte_ok && (cmd_q.op == rfbre_pkg::OP_READ);
      mem_we   = byte_ok && (cmd_q.op == rfbre_pkg::OP_WRITE);
    end
  end

  always_comb begin
    logic pix_done;
    state_d    = state_q;
    cmd_d      = cmd_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    end_d      = end_q;
    row_d      = row_q;
    horiz_d    = horiz_q;
    seg_d      = seg_q;
    dropped_d  = dropped_q;
    nx_d       = nx_q;
    ny_d       = ny_q;
    pix_addr_d = pix_addr_q;
    bit_d      = bit_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    pix_done   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d     = in_cmd;
          dropped_d = 1'b0;
          seg_d     = 2'd0;
          row_d     = in_cmd.y_first;
          case (in_cmd.op)
            rfbre_pkg::OP_PIXEL, rfbre_pkg::OP_HLINE,
            rfbre_pkg::OP_VLINE, rfbre_pkg::OP_RECT: state_d = S_SEG;
            rfbre_pkg::OP_BOX:
              state_d = (in_cmd.y_first > in_cmd.y_second) ? S_DONE : S_SEG;
            rfbre_pkg::OP_READ, rfbre_pkg::OP_WRITE: state_d = S_BYTE;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SEG: begin
        state_d = S_MAP;
        horiz_d = 1'b1;
        cur_x_d = x_lo;
        end_d   = x_hi;
        cur_y_d = y1;
        case (cmd_q.op)
          rfbre_pkg::OP_PIXEL: begin
            cur_x_d = x1;
            end_d   = x1;
          end
          rfbre_pkg::OP_HLINE: ;
          rfbre_pkg::OP_VLINE: begin
            horiz_d = 1'b0;
            cur_x_d = x1;
            cur_y_d = y_lo;
            end_d   = y_hi;
          end
          rfbre_pkg::OP_RECT: begin
            case (seg_q)
              2'd0: cur_y_d = y1;
              2'd1: cur_y_d = y2;
              default: begin
                horiz_d = 1'b0;
                cur_x_d = (seg_q == 2'd2) ? x1 : x2;
                cur_y_d = y_lo;
                end_d   = y_hi;
              end
            endcase
          end
          default: cur_y_d = row_q;
        endcase
      end
      S_MAP: begin
        state_d = S_ADDR;
        case (rotation_q)
          2'd0: begin
            nx_d = cx_ext;
            ny_d = cy_ext;
          end
          2'd1: begin
            nx_d = w_ext - MW'(1) - cy_ext;
            ny_d = cx_ext;
          end
          2'd2: begin
            nx_d = w_ext - MW'(1) - cx_ext;
            ny_d = h_ext - MW'(1) - cy_ext;
          end
          default: begin
            nx_d = cy_ext;
            ny_d = h_ext - MW'(1) - cx_ext;
          end
        endcase
        if (mirror_q) begin
          nx_d = nx_d + pad_ext;
        end
      end
      S_ADDR: begin
        pix_addr_d = pos[AW-1:0];
        bit_d      = nx_q[2:0];
        if (addr_drop) begin
          dropped_d = 1'b1;
          pix_done  = 1'b1;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_WR;
      S_WR: pix_done = 1'b1;
      S_BYTE: begin
        dropped_d = !byte_ok && (cmd_q.op == rfbre_pkg::OP_READ ||
                                 cmd_q.op == rfbre_pkg::OP_WRITE);
        state_d   = S_DONE;
      end
      default: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          if (cmd_q.op == rfbre_pkg::OP_READ && !dropped_q) begin
            m_data_d = {7'd0, rd_red_q, rd_black_q, dropped_q};
          end else begin
            m_data_d = {16'd0, 7'd0, dropped_q};
          end
          state_d = S_IDLE;
        end
      end
    endcase

    if (pix_done) begin
      if (run_pos != end_q) begin
        state_d = S_MAP;
        if (horiz_q) begin
          cur_x_d = cur_x_q + CW'(1);
        end else begin
          cur_y_d = cur_y_q + CW'(1);
        end
      end else if (cmd_q.op == rfbre_pkg::OP_RECT && seg_q != 2'd3) begin
        seg_d   = seg_q + 2'd1;
        state_d = S_SEG;
      end else if (cmd_q.op == rfbre_pkg::OP_BOX && row_q != y2) begin
        row_d   = row_q + CW'(1);
        state_d = S_SEG;
      end else begin
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    end_q      <= end_d;
    row_q      <= row_d;
    horiz_q    <= horiz_d;
    seg_q      <= seg_d;
    dropped_q  <= dropped_d;
    nx_q       <= nx_d;
    ny_q       <= ny_d;
    pix_addr_q <= pix_addr_d;
    bit_q      <= bit_d;
    m_data_q   <= m_data_d;
  end

  // Plane memories, one access port each with registered read data.
  logic [7:0] black_mem [rfbre_pkg::FB_BYTES];
  logic [7:0] red_mem   [rfbre_pkg::FB_BYTES];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      black_mem[mem_addr] <= wr_black;
      red_mem[mem_addr]   <= wr_red;
    end
    if (mem_re) begin
      rd_black_q <= black_mem[mem_addr];
      rd_red_q   <= red_mem[mem_addr];
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("engine accepted a beat and stayed ready");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> ($past(state_q) == S_RD))
    else $error("pixel write without a preceding read");

  a_drop_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR && addr_drop) |=> (state_q != S_RD))
    else $error("dropped pixel reached the memory");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside the completion state");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the rotated framebuffer raster engine, with its own pixel predictor.
module testbench;
  import rfbre_pkg::*;

  typedef struct packed {
    logic       status;
    logic [7:0] black;
    logic [7:0] red;
  } reply_t;

  typedef struct {
    cmd_t   cmd;
    bit     checked;
    reply_t reply;
  } script_row_t;

  localparam int STALL_LIMIT = 60000;
  localparam int PHASES      = 8;
  localparam int PHASE_CMDS  = 144;
  localparam int HOLD_CYCLES = 400;

  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam logic [1:0] COL_UNUSED = 2'd3;

  localparam reply_t DONE    = '{status: 1'b0, black: 8'h00, red: 8'h00};
  localparam reply_t DROPPED = '{status: 1'b1, black: 8'h00, red: 8'h00};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DAT_W-1:0]  cfg_wdata_i   = '0;

  // The typed reply of a directed row travels alongside its beat.
  logic   beat_checked = 1'b0;
  reply_t beat_reply   = '0;

  logic [1:0]  set_rotation  = 2'd0;
  logic        set_mirror    = 1'b0;
  logic        set_red_en    = 1'b0;
  logic [10:0] set_width     = 11'd128;
  logic [10:0] set_height    = 11'd296;
  logic [7:0]  set_pad       = 8'd0;
  logic [7:0]  set_row_bytes = 8'd16;

  logic [7:0] black_plane_q [FB_BYTES];
  logic [7:0] red_plane_q   [FB_BYTES];
  bit         byte_written  [FB_BYTES];
  int         written_addrs [$];
  int         drawn_addrs   [$];
  bit         px_dropped;
  reply_t     pending_replies [$];

  int offer_gap_pct = 0;
  int take_gap_pct  = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int faults        = 0;
  int replies_seen  = 0;
  int cmds_taken    = 0;
  int reads_taken   = 0;
  int drops_seen    = 0;
  int settings_done = 0;

  rotated_framebuffer_raster_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void plot_pixel(int x, int y, logic [1:0] colour);
    longint     nx;
    longint     ny;
    longint     pos;
    logic [7:0] mask;
    case (set_rotation)
      2'd0: begin
        nx = x;
        ny = y;
      end
      2'd1: begin
        nx = longint'(set_width) - 1 - y;
        ny = x;
      end
      2'd2: begin
        nx = longint'(set_width) - 1 - x;
        ny = longint'(set_height) - 1 - y;
      end
      default: begin
        nx = y;
        ny = longint'(set_height) - 1 - x;
      end
    endcase
    if (set_mirror) nx = nx + longint'(set_pad);
    if (nx < 0 || ny < 0) begin
      px_dropped = 1'b1;
      return;
    end
    pos = ny * longint'(set_row_bytes) + (nx >>> 3);
    if (pos >= longint'(FB_BYTES)) begin
      px_dropped = 1'b1;
      return;
    end
    mask = PIX_MSB >> nx[2:0];
    if (colour != COL_WHITE) black_plane_q[pos] = black_plane_q[pos] & ~mask;
    if (set_red_en && colour == COL_RED) red_plane_q[pos] = red_plane_q[pos] | mask;
    drawn_addrs.push_back(int'(pos));
    if (drawn_addrs.size() > 64) void'(drawn_addrs.pop_front());
  endfunction

  function automatic void draw_row(int y, int a, int b, logic [1:0] colour);
    int lo;
    int hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    for (int x = lo; x <= hi; x++) plot_pixel(x, y, colour);
  endfunction

  function automatic void draw_column(int x, int a, int b, logic [1:0] colour);
    int lo;
    int hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    for (int y = lo; y <= hi; y++) plot_pixel(x, y, colour);
  endfunction

  function automatic reply_t raster_reply(cmd_t c);
    int     x1;
    int     y1;
    int     x2;
    int     y2;
    reply_t r;
    x1 = c.x_first;
    y1 = c.y_first;
    x2 = c.x_second;
    y2 = c.y_second;
    r = DONE;
    px_dropped = 1'b0;
    case (c.op)
      OP_PIXEL: plot_pixel(x1, y1, c.color);
      OP_HLINE: draw_row(y1, x1, x2, c.color);
      OP_VLINE: draw_column(x1, y1, y2, c.color);
      OP_RECT: begin
        draw_row(y1, x1, x2, c.color);
        draw_row(y2, x1, x2, c.color);
        draw_column(x1, y1, y2, c.color);
        draw_column(x2, y1, y2, c.color);
      end
      OP_BOX: begin
        for (int y = y1; y <= y2; y++) draw_row(y, x1, x2, c.color);
      end
      // A 13-bit address never reaches beyond the buffer here.
      OP_READ: begin
        r.black = black_plane_q[c.byte_addr];
        r.red   = red_plane_q[c.byte_addr];
      end
      OP_WRITE: begin
        black_plane_q[c.byte_addr] = c.black_byte_in;
        red_plane_q[c.byte_addr]   = c.red_byte_in;
        if (!byte_written[c.byte_addr]) begin
          byte_written[c.byte_addr] = 1'b1;
          written_addrs.push_back(int'(c.byte_addr));
        end
      end
      default: ;
    endcase
    r.status = px_dropped;
    return r;
  endfunction

  function automatic cmd_t cmd_of(logic [2:0] op, int x1, int y1, int x2, int y2,
                                  logic [1:0] colour, int addr, int bb, int rb);
    cmd_t c;
    c.op            = op;
    c.x_first       = COORD_W'(x1);
    c.y_first       = COORD_W'(y1);
    c.x_second      = COORD_W'(x2);
    c.y_second      = COORD_W'(y2);
    c.color         = colour;
    c.byte_addr     = BADDR_W'(addr);
    c.black_byte_in = 8'(bb);
    c.red_byte_in   = 8'(rb);
    return c;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -1024) return -1024;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // Mostly near the origin or the far screen edge, where rotated pixels land in the buffer.
  function automatic int pick_coord();
    int roll;
    int far_end;
    roll = $urandom_range(0, 99);
    far_end = ($urandom_range(0, 1) != 0) ? int'(set_width) - 1 : int'(set_height) - 1;
    if (roll < 70) return int'($urandom_range(0, 44)) - 4;
    if (roll < 85) return clamp_coord(far_end - int'($urandom_range(0, 40)));
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int offset_by(int v, int reach);
    int d;
    d = $urandom_range(0, reach);
    return clamp_coord(($urandom_range(0, 1) != 0) ? v + d : v - d);
  endfunction

  function automatic cmd_t random_cmd();
    logic [95:0] noise;
    cmd_t        c;
    int          roll;
    int          x1;
    int          y1;
    int          reach;
    noise = {$urandom(), $urandom(), $urandom()};
    c = noise[$bits(cmd_t)-1:0];
    x1 = pick_coord();
    y1 = pick_coord();
    reach = ($urandom_range(0, 24) == 0) ? 2047 : 12;
    roll = $urandom_range(0, 99);
    if (roll < 14) begin
      c.op = OP_PIXEL;
    end else if (roll < 28) begin
      c.op = OP_HLINE;
      c.x_second = COORD_W'(offset_by(x1, reach));
    end else if (roll < 42) begin
      c.op = OP_VLINE;
      c.y_second = COORD_W'(offset_by(y1, reach));
    end else if (roll < 52) begin
      c.op = OP_RECT;
      reach = ($urandom_range(0, 29) == 0) ? 200 : 20;
      c.x_second = COORD_W'(offset_by(x1, reach));
      c.y_second = COORD_W'(offset_by(y1, reach));
    end else if (roll < 62) begin
      c.op = OP_BOX;
      c.x_second = COORD_W'(offset_by(x1, 12));
      c.y_second = COORD_W'(clamp_coord(y1 + int'($urandom_range(0, 10)) - 2));
    end else if (roll < 78) begin
      c.op = OP_READ;
      c.byte_addr = BADDR_W'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
    end else if (roll < 97) begin
      c.op = OP_WRITE;
      roll = $urandom_range(0, 99);
      if (roll < 40 && drawn_addrs.size() != 0) begin
        c.byte_addr = BADDR_W'(drawn_addrs[$urandom_range(0, drawn_addrs.size() - 1)]);
      end else if (roll < 70) begin
        c.byte_addr = BADDR_W'($urandom_range(0, 1023));
      end
    end else begin
      c.op = OP_UNUSED;
    end
    c.x_first = COORD_W'(x1);
    c.y_first = COORD_W'(y1);
    return c;
  endfunction

  task automatic offer_cmd(cmd_t c, bit checked, reply_t reply);
    while ($urandom_range(0, 99) < offer_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, c.red_byte_in, c.black_byte_in, c.byte_addr, c.color,
                      c.y_second, c.x_second, c.y_first, c.x_first};
    s_axis_tuser  <= c.op;
    beat_checked  <= checked;
    beat_reply    <= reply;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Deassert tvalid and let the monitor book the last accepted command before waiting for the replies.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_DAT_W'(value);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      holds_served  <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= hold_requests;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= take_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    cmd_t   got;
    reply_t seen;
    reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      seen = '{status: m_axis_tdata[0], black: m_axis_tdata[8:1], red: m_axis_tdata[16:9]};
      replies_seen++;
      if (pending_replies.size() == 0) begin
        faults++;
        if (faults <= 10) $display("reply beat %0d arrived with no command outstanding: %h",
                                   replies_seen, seen);
      end else begin
        want = pending_replies.pop_front();
        if (seen.status !== want.status || seen.black !== want.black ||
            seen.red !== want.red) begin
          faults++;
          if (faults <= 10)
            $display("reply beat %0d: expected status %0d black %h red %h, got %0d %h %h",
                     replies_seen, want.status, want.black, want.red,
                     seen.status, seen.black, seen.red);
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      got.op            = s_axis_tuser;
      got.x_first       = s_axis_tdata[10:0];
      got.y_first       = s_axis_tdata[21:11];
      got.x_second      = s_axis_tdata[32:22];
      got.y_second      = s_axis_tdata[43:33];
      got.color         = s_axis_tdata[45:44];
      got.byte_addr     = s_axis_tdata[58:46];
      got.black_byte_in = s_axis_tdata[66:59];
      got.red_byte_in   = s_axis_tdata[74:67];
      want = raster_reply(got);
      cmds_taken++;
      if (got.op == OP_READ) reads_taken++;
      if (want.status) drops_seen++;
      pending_replies.push_back(beat_checked ? beat_reply : want);
    end
    if (cfg_we_i) begin
      settings_done++;
      case (cfg_index_i)
        REG_ROTATION:  set_rotation  = cfg_wdata_i[1:0];
        REG_MIRROR:    set_mirror    = cfg_wdata_i[0];
        REG_RED_EN:    set_red_en    = cfg_wdata_i[0];
        REG_WIDTH:     set_width     = cfg_wdata_i;
        REG_HEIGHT:    set_height    = cfg_wdata_i;
        REG_PAD:       set_pad       = cfg_wdata_i[7:0];
        REG_ROW_BYTES: set_row_bytes = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
    quiet_cycles <= ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) ?
                    0 : quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    script_row_t script [$];
    int          setting [7];
    script = '{
      '{cmd_of(OP_WRITE, 0, 0, 0, 0, COL_BLACK, 0, 'hFF, 'h00), 1'b1, DONE},
      '{cmd_of(OP_WRITE, 0, 0, 0, 0, COL_BLACK, 1, 'hFF, 'h0F), 1'b1, DONE},
      '{cmd_of(OP_WRITE, 0, 0, 0, 0, COL_BLACK, 16, 'hFF, 'hFF), 1'b1, DONE},
      '{cmd_of(OP_WRITE, 0, 0, 0, 0, COL_BLACK, 17, 'hFF, 'h00), 1'b1, DONE},
      '{cmd_of(OP_WRITE, 0, 0, 0, 0, COL_BLACK, 8191, 'hA5, 'h5A), 1'b1, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 8191, 0, 0), 1'b1,
        '{status: 1'b0, black: 8'hA5, red: 8'h5A}},
      '{cmd_of(OP_PIXEL, 0, 0, 0, 0, COL_BLACK, 0, 0, 0), 1'b1, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 0, 0, 0), 1'b1,
        '{status: 1'b0, black: 8'h7F, red: 8'h00}},
      '{cmd_of(OP_PIXEL, -1, 0, 0, 0, COL_BLACK, 0, 0, 0), 1'b1, DROPPED},
      '{cmd_of(OP_PIXEL, 0, -1024, 0, 0, COL_BLACK, 0, 0, 0), 1'b1, DROPPED},
      '{cmd_of(OP_PIXEL, 1023, 1023, 0, 0, COL_RED, 0, 0, 0), 1'b1, DROPPED},
      '{cmd_of(OP_HLINE, 15, 0, 8, 0, COL_WHITE, 0, 0, 0), 1'b1, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 1, 0, 0), 1'b1,
        '{status: 1'b0, black: 8'hFF, red: 8'h0F}},
      '{cmd_of(OP_HLINE, 12, 0, 3, 0, COL_RED, 0, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_VLINE, 9, 1, 0, 0, COL_BLACK, 0, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_RECT, 6, 1, 1, 0, COL_RED, 0, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_BOX, 0, 5, 7, 2, COL_BLACK, 0, 0, 0), 1'b1, DONE},
      '{cmd_of(OP_BOX, 8, 1, 15, 1, COL_UNUSED, 0, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_UNUSED, -1024, 1023, -1, 5, COL_RED, 8191, 'hFF, 'hFF), 1'b1, DONE},
      '{cmd_of(OP_HLINE, 120, 0, 135, 0, COL_BLACK, 0, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 0, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 1, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 16, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_READ, 0, 0, 0, 0, COL_BLACK, 17, 0, 0), 1'b0, DONE},
      '{cmd_of(OP_PIXEL, 1023, -1, 0, 0, COL_WHITE, 0, 0, 0), 1'b1, DROPPED}
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    offer_gap_pct = 18;
    take_gap_pct  = 68;
    foreach (script[i]) offer_cmd(script[i].cmd, script[i].checked, script[i].reply);
    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      case (p)
        0: setting = '{1, 1, 1, 128, 296, 3, 16};
        1: setting = '{2, 0, 1, 1024, 1024, 0, 128};
        2: setting = '{3, 1, 0, 1, 1, 255, 1};
        3: setting = '{0, 1, 1, 64, 64, 255, 8};
        default: begin
          setting = '{$urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(1, 300), $urandom_range(1, 300),
                      $urandom_range(0, 255), $urandom_range(1, 32)};
        end
      endcase
      offer_gap_pct = (p < 3) ? 18 : (p < 6) ? 68 : 0;
      take_gap_pct  = (p < 3) ? 68 : (p < 6) ? 18 : 0;
      write_setting(REG_ROTATION, setting[0]);
      write_setting(REG_MIRROR, setting[1]);
      write_setting(REG_RED_EN, setting[2]);
      write_setting(REG_WIDTH, setting[3]);
      write_setting(REG_HEIGHT, setting[4]);
      write_setting(REG_PAD, setting[5]);
      write_setting(REG_ROW_BYTES, setting[6]);
      cfg_we_i <= 1'b0;
      for (int n = 0; n < PHASE_CMDS; n++) begin
        if (p == 1 && n == 40) hold_requests <= hold_requests + 1;
        if (p == 4 && n == 70) drain_replies();
        offer_cmd(random_cmd(), 1'b0, DONE);
      end
    end
    drain_replies();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d commands, %0d of them byte reads and %0d with dropped pixels,",
             cmds_taken, reads_taken, drops_seen);
    $display("under %0d register writes across all rotations, mirror and plane settings.",
             settings_done);
    if (faults == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
